// File: rtl/spi_adc_init_and_poll_sequencer_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef SPI_ADC_INIT_AND_POLL_SEQUENCER_MACROS_SVH
`define SPI_ADC_INIT_AND_POLL_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPIADC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spiadc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPIADC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spiadc assertion failed");

`endif

// File: rtl/spiadc_pkg.sv
`timescale 1ns / 1ps

package spiadc_pkg;

    // Slot kinds on the input stream
    localparam logic [1:0] ACT_SLOT = 2'd0;
    localparam logic [1:0] ACT_INIT = 2'd1;
    localparam logic [1:0] ACT_POLL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ADC_CONFIG = 2'd0;
    localparam logic [1:0] CFG_CYCLE      = 2'd1;
    localparam logic [1:0] CFG_MASK       = 2'd2;
    localparam logic [1:0] CFG_CONTROL    = 2'd3;

    localparam logic [23:0] RST_ADC_CONFIG = 24'h010011;
    localparam logic [23:0] RST_CYCLE      = 24'd244;
    localparam logic [23:0] RST_MASK       = 24'h800000;
    localparam logic [23:0] RST_CONTROL    = 24'h000004;

    // Program kinds
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Init program steps
    localparam logic [4:0] INIT_WR_STATUS = 5'd9;
    localparam logic [4:0] INIT_WR_CONFIG = 5'd10;
    localparam logic [4:0] INIT_WR_CYCLE  = 5'd11;
    localparam logic [4:0] INIT_WR_MASK   = 5'd12;
    localparam logic [4:0] INIT_WR_CTRL   = 5'd13;
    localparam logic [4:0] INIT_LAST      = 5'd14;

    // Poll program steps
    localparam logic [4:0] POLL_STATUS = 5'd0;
    localparam logic [4:0] POLL_RAW    = 5'd1;
    localparam logic [4:0] POLL_FILT1  = 5'd2;
    localparam logic [4:0] POLL_FILT2  = 5'd3;
    localparam logic [4:0] POLL_CLEAR  = 5'd4;

    // Converter register addresses
    localparam logic [4:0] ADDR_CONFIG  = 5'd0;
    localparam logic [4:0] ADDR_CH1_RAW = 5'd7;
    localparam logic [4:0] ADDR_CH1_FLT = 5'd11;
    localparam logic [4:0] ADDR_CH2_FLT = 5'd12;
    localparam logic [4:0] ADDR_STATUS  = 5'd15;
    localparam logic [4:0] ADDR_CYCLE   = 5'd5;
    localparam logic [4:0] ADDR_MASK    = 5'd26;
    localparam logic [4:0] ADDR_CONTROL = 5'd28;

    localparam logic [7:0]  CMD_START_CONV = 8'hE8;
    localparam logic [23:0] STATUS_ALL     = 24'hFFFFFF;
    localparam logic [23:0] STATUS_DRDY    = 24'h800000;
    localparam logic [23:0] SYNC0_FILL     = 24'hFEFEFE;

    localparam logic [5:0] CMD_BITS   = 6'd8;
    localparam logic [5:0] FRAME_BITS = 6'd32;

    typedef enum logic [2:0] {
        TX_CMD   = 3'b001,
        TX_READ  = 3'b010,
        TX_WRITE = 3'b100
    } tx_kind_t;

    typedef struct packed {
        logic [1:0] action;
        logic       dout_bit;
    } item_t;

    typedef struct packed {
        logic        chip_select_n;
        logic        data_in_bit;
        logic        clock_pulse;
        logic        sample_valid;
        logic        sample_channel;
        logic [23:0] sample_value;
        logic        busy_res;
    } res_t;

    typedef struct packed {
        logic running;
        logic bit_zero;
    } stat_t;

    function automatic logic [7:0] init_cmd(input logic [3:0] step);
        logic [7:0] cmd;
        case (step)
            4'd0:    cmd = 8'hA0;
            4'd1:    cmd = 8'h80;
            4'd5:    cmd = 8'hFE;
            default: cmd = 8'hFF;
        endcase
        return cmd;
    endfunction

    function automatic logic [31:0] read_frame(input logic [4:0] addr);
        return {2'b00, addr, 1'b0, SYNC0_FILL};
    endfunction

    function automatic logic [31:0] write_frame(input logic [4:0] addr,
                                                input logic [23:0] value);
        return {2'b01, addr, 1'b0, value};
    endfunction

endpackage

// File: rtl/spiadc_in_reg.sv
`timescale 1ns / 1ps

module spiadc_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [0] dout_bit, [7:1] zero
    input  logic [1:0]          s_tuser,   // [1:0] action
    input  logic                advance,
    output logic                item_vld,
    output spiadc_pkg::item_t   item
);

    logic              vld_reg;
    spiadc_pkg::item_t item_reg;

    assign s_tready = !vld_reg || advance;
    assign item_vld = vld_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.action   <= s_tuser;
            item_reg.dout_bit <= s_tdata[0];
        end
    end

endmodule

// File: rtl/spiadc_seq.sv
`timescale 1ns / 1ps

module spiadc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [23:0]        cfg_wdata,
    input  logic               fire,
    input  spiadc_pkg::item_t  item,
    output spiadc_pkg::res_t   res,
    output spiadc_pkg::stat_t  stat
);

    logic [23:0] adc_cfg_reg;
    logic [23:0] cycle_reg;
    logic [23:0] mask_reg;
    logic [23:0] ctrl_reg;

    logic [4:0]  step_reg,    step_next;
    logic        kind_reg,    kind_next;
    logic [5:0]  bitcnt_reg,  bitcnt_next;
    logic [31:0] shout_reg,   shout_next;
    logic [23:0] shin_reg,    shin_next;
    logic        running_reg, running_next;

    spiadc_pkg::tx_kind_t tx_kind;
    logic [31:0]          frame;
    logic [23:0]          wr_value;
    logic [5:0]           tx_len;

    assign stat.running  = running_reg;
    assign stat.bit_zero = (bitcnt_reg == 6'd0);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_cfg_reg <= spiadc_pkg::RST_ADC_CONFIG;
            cycle_reg   <= spiadc_pkg::RST_CYCLE;
            mask_reg    <= spiadc_pkg::RST_MASK;
            ctrl_reg    <= spiadc_pkg::RST_CONTROL;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                spiadc_pkg::CFG_ADC_CONFIG: adc_cfg_reg <= cfg_wdata;
                spiadc_pkg::CFG_CYCLE:      cycle_reg   <= cfg_wdata;
                spiadc_pkg::CFG_MASK:       mask_reg    <= cfg_wdata;
                spiadc_pkg::CFG_CONTROL:    ctrl_reg    <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Frame for the current program step
    always_comb
    begin
        case (step_reg)
            spiadc_pkg::INIT_WR_STATUS: wr_value = spiadc_pkg::STATUS_ALL;
            spiadc_pkg::INIT_WR_CONFIG: wr_value = adc_cfg_reg;
            spiadc_pkg::INIT_WR_CYCLE:  wr_value = cycle_reg;
            spiadc_pkg::INIT_WR_MASK:   wr_value = mask_reg;
            default:                    wr_value = ctrl_reg;
        endcase

        if (kind_reg == spiadc_pkg::KIND_INIT)
        begin
            if (step_reg < spiadc_pkg::INIT_WR_STATUS)
            begin
                tx_kind = spiadc_pkg::TX_CMD;
                frame   = {spiadc_pkg::init_cmd(step_reg[3:0]), 24'd0};
            end
            else if (step_reg < spiadc_pkg::INIT_LAST)
            begin
                tx_kind = spiadc_pkg::TX_WRITE;
                case (step_reg)
                    spiadc_pkg::INIT_WR_STATUS:
                        frame = spiadc_pkg::write_frame(spiadc_pkg::ADDR_STATUS, wr_value);
                    spiadc_pkg::INIT_WR_CONFIG:
                        frame = spiadc_pkg::write_frame(spiadc_pkg::ADDR_CONFIG, wr_value);
                    spiadc_pkg::INIT_WR_CYCLE:
                        frame = spiadc_pkg::write_frame(spiadc_pkg::ADDR_CYCLE, wr_value);
                    spiadc_pkg::INIT_WR_MASK:
                        frame = spiadc_pkg::write_frame(spiadc_pkg::ADDR_MASK, wr_value);
                    default:
                        frame = spiadc_pkg::write_frame(spiadc_pkg::ADDR_CONTROL, wr_value);
                endcase
            end
            else
            begin
                tx_kind = spiadc_pkg::TX_CMD;
                frame   = {spiadc_pkg::CMD_START_CONV, 24'd0};
            end
        end
        else
        begin
            tx_kind = spiadc_pkg::TX_READ;
            case (step_reg)
                spiadc_pkg::POLL_STATUS:
                    frame = spiadc_pkg::read_frame(spiadc_pkg::ADDR_STATUS);
                spiadc_pkg::POLL_RAW:
                    frame = spiadc_pkg::read_frame(spiadc_pkg::ADDR_CH1_RAW);
                spiadc_pkg::POLL_FILT1:
                    frame = spiadc_pkg::read_frame(spiadc_pkg::ADDR_CH1_FLT);
                spiadc_pkg::POLL_FILT2:
                    frame = spiadc_pkg::read_frame(spiadc_pkg::ADDR_CH2_FLT);
                default:
                begin
                    tx_kind = spiadc_pkg::TX_WRITE;
                    frame   = spiadc_pkg::write_frame(spiadc_pkg::ADDR_STATUS,
                                                      spiadc_pkg::STATUS_DRDY);
                end
            endcase
        end

        tx_len = (tx_kind == spiadc_pkg::TX_CMD) ? spiadc_pkg::CMD_BITS
                                                 : spiadc_pkg::FRAME_BITS;
    end

    // Slot evaluation
    always_comb
    begin
        step_next    = step_reg;
        kind_next    = kind_reg;
        bitcnt_next  = bitcnt_reg;
        shout_next   = shout_reg;
        shin_next    = shin_reg;
        running_next = running_reg;

        res.chip_select_n  = 1'b1;
        res.data_in_bit    = 1'b0;
        res.clock_pulse    = 1'b0;
        res.sample_valid   = 1'b0;
        res.sample_channel = 1'b0;
        res.sample_value   = 24'd0;
        res.busy_res       = 1'b0;

        if (!running_reg)
        begin
            if (item.action == spiadc_pkg::ACT_INIT || item.action == spiadc_pkg::ACT_POLL)
            begin
                running_next = 1'b1;
                kind_next    = (item.action == spiadc_pkg::ACT_POLL);
                step_next    = 5'd0;
                bitcnt_next  = 6'd0;
                shin_next    = 24'd0;
                res.busy_res = 1'b1;
            end
        end
        else
        begin
            res.busy_res = 1'b1;
            if (bitcnt_reg == 6'd0)
            begin
                shout_next  = frame;
                shin_next   = 24'd0;
                bitcnt_next = 6'd1;
            end
            else
            begin
                res.chip_select_n = 1'b0;
                res.clock_pulse   = 1'b1;
                res.data_in_bit   = shout_reg[31];
                shout_next        = {shout_reg[30:0], 1'b0};
                if (tx_kind == spiadc_pkg::TX_READ && bitcnt_reg > spiadc_pkg::CMD_BITS)
                begin
                    shin_next = {shin_reg[22:0], item.dout_bit};
                end
                if (bitcnt_reg >= tx_len)
                begin
                    bitcnt_next = 6'd0;
                    if (kind_reg == spiadc_pkg::KIND_INIT)
                    begin
                        if (step_reg >= spiadc_pkg::INIT_LAST)
                        begin
                            running_next = 1'b0;
                        end
                        else
                        begin
                            step_next = step_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        case (step_reg)
                            spiadc_pkg::POLL_STATUS:
                            begin
                                if (shin_next[23])
                                begin
                                    step_next = spiadc_pkg::POLL_RAW;
                                end
                                else
                                begin
                                    running_next = 1'b0;
                                end
                            end
                            spiadc_pkg::POLL_RAW:
                            begin
                                if (shin_next[23])
                                begin
                                    res.sample_valid = 1'b1;
                                    step_next        = spiadc_pkg::POLL_FILT2;
                                end
                                else
                                begin
                                    step_next = spiadc_pkg::POLL_FILT1;
                                end
                            end
                            spiadc_pkg::POLL_FILT1:
                            begin
                                res.sample_valid = 1'b1;
                                res.sample_value = shin_next;
                                step_next        = spiadc_pkg::POLL_FILT2;
                            end
                            spiadc_pkg::POLL_FILT2:
                            begin
                                res.sample_valid   = 1'b1;
                                res.sample_channel = 1'b1;
                                res.sample_value   = shin_next;
                                step_next          = spiadc_pkg::POLL_CLEAR;
                            end
                            default:
                            begin
                                running_next = 1'b0;
                            end
                        endcase
                    end
                end
                else
                begin
                    bitcnt_next = bitcnt_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= 5'd0;
            kind_reg    <= 1'b0;
            bitcnt_reg  <= 6'd0;
            shout_reg   <= 32'd0;
            shin_reg    <= 24'd0;
            running_reg <= 1'b0;
        end
        else if (fire)
        begin
            step_reg    <= step_next;
            kind_reg    <= kind_next;
            bitcnt_reg  <= bitcnt_next;
            shout_reg   <= shout_next;
            shin_reg    <= shin_next;
            running_reg <= running_next;
        end
    end

endmodule

// File: rtl/spiadc_out_reg.sv
`timescale 1ns / 1ps

module spiadc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  spiadc_pkg::res_t  res,
    output logic              advance,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [0:0]        m_tuser
);

    logic             vld_reg;
    spiadc_pkg::res_t res_reg;

    assign advance  = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata  = {3'd0, res_reg.busy_res, res_reg.sample_value, res_reg.sample_valid,
                       res_reg.clock_pulse, res_reg.data_in_bit, res_reg.chip_select_n};
    assign m_tuser  = res_reg.sample_channel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= load;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/spi_adc_init_and_poll_sequencer.sv
`timescale 1ns / 1ps
// Serial ADC init and poll sequencer. Each input transfer is one bit slot (or a
// start request for the init or poll program) and yields exactly one output
// transfer with chip select, data-in, clock pulse, busy and any finished sample.
// An input register and a result register bracket the sequencer logic, so each
// item is registered in both on its way from input transfer to result, and
// throughput is one item per clock while the output side is ready.
// Write configuration only while no program runs and no item is in flight; a write
// takes effect at the next edge.

module spi_adc_init_and_poll_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] dout_bit, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] chip_select_n, [1] data_in_bit, [2] clock_pulse,
                                   // [3] sample_valid, [27:4] sample_value, [28] busy_res
    output logic [0:0]  m_tuser,   // [0] sample_channel
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

`include "spi_adc_init_and_poll_sequencer_macros.svh"

    logic              advance;
    logic              item_vld;
    logic              fire;
    spiadc_pkg::item_t item;
    spiadc_pkg::res_t  res;
    spiadc_pkg::stat_t stat;

    assign fire = item_vld && advance;

    spiadc_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    spiadc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .res       (res),
        .stat      (stat)
    );

    spiadc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `SPIADC_ASSERT_NOW(a_idle_bit_zero, !stat.running, stat.bit_zero)
    `SPIADC_ASSERT_NOW(a_clk_selected, m_tvalid && m_tdata[2], !m_tdata[0] && m_tdata[28])
    `SPIADC_ASSERT_NEXT(a_start_runs, fire && !stat.running && (item.action == spiadc_pkg::ACT_INIT || item.action == spiadc_pkg::ACT_POLL), stat.running && stat.bit_zero)

endmodule
